>>> hdl/rvs_pkg.sv
// Shared types and constants of the regulator voltage selector.
package rvs_pkg;

  localparam int UV_W      = 23;  // microvolt fields
  localparam int SEL_W     = 4;   // selector width
  localparam int CNT_W     = 5;   // level count register
  localparam int ACC_W     = UV_W + SEL_W;  // base + 15 * step never wraps here
  localparam int SEL_LIMIT = 16;  // indices a selector can name
  localparam int CFG_IDX_W = 3;

  localparam int IN_TDATA_W  = 48;  // 46 bits of fields, padded to bytes
  localparam int OUT_TDATA_W = 32;  // 28 bits of fields, padded to bytes

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TADDR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TDATA  = 3'd6;

  // level source modes; the unused code behaves as constant mode
  localparam logic [1:0] MODE_TABLE  = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_CONST  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CONST,
    ST_DONE
  } state_t;

  // result of the shared compare / step unit
  typedef struct packed {
    logic             fit;   // candidate lies inside [lo, hi]
    logic [ACC_W-1:0] next;  // accumulator plus one step
  } unit_res_t;

endpackage

>>> hdl/rvs_ram.sv
// Generic single write port RAM with registered read.
module rvs_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/rvs_unit.sv
// Shared window compare and linear step adder.
module rvs_unit (
  input  logic [rvs_pkg::ACC_W-1:0] cand,
  input  logic [rvs_pkg::UV_W-1:0]  lo,
  input  logic [rvs_pkg::UV_W-1:0]  hi,
  input  logic [rvs_pkg::ACC_W-1:0] acc,
  input  logic [rvs_pkg::UV_W-1:0]  step,
  output rvs_pkg::unit_res_t        res
);
  import rvs_pkg::*;

  logic [ACC_W-1:0] lo_x;
  logic [ACC_W-1:0] hi_x;

  assign lo_x = {{SEL_W{1'b0}}, lo};
  assign hi_x = {{SEL_W{1'b0}}, hi};

  // levels above the 23-bit range stay wide here, so they never fit
  assign res.fit  = (lo_x <= cand) && (cand <= hi_x);
  assign res.next = acc + {{SEL_W{1'b0}}, step};

endmodule

>>> hdl/regulator_voltage_selector.sv
// Top level of the regulator voltage selector: config, sequencer, result register.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in      | in  | in_tvalid/in_tready   | in_tdata: min_uv[22:0], max_uv[45:23]
//  out     | out | out_tvalid/out_tready | out_tdata: status[0], chosen_selector[4:1],
//          |     |                      |   chosen_uv[27:5]
//  cfg     | in  | cfg_we               | cfg_index, cfg_wdata
//
//  Sequence: table/linear mode tests up to 16 levels, one per cycle through the
//  shared compare unit (in table mode also the level RAM read port), then
//  presents the result; constant mode makes one compare, and a zero level
//  count goes straight to the result.
//  Reset clears the config registers, the latched selector and the sequencer;
//  level table contents are undefined until written.
//  in_tready is high only in idle; a result held by out_tready stalls the
//  next item.
module regulator_voltage_selector #(
  parameter int MAX_LEVELS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rvs_pkg::IN_TDATA_W-1:0]    in_tdata,   // min_uv, max_uv
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rvs_pkg::OUT_TDATA_W-1:0]   out_tdata,  // status, chosen_selector, chosen_uv
  input  logic                              cfg_we,
  input  logic [rvs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rvs_pkg::UV_W-1:0]          cfg_wdata
);
  import rvs_pkg::*;

  // only the first 16 entries are addressable through a 4-bit table address
  localparam int TBL_DEPTH = (MAX_LEVELS < SEL_LIMIT) ? MAX_LEVELS : SEL_LIMIT;
  localparam int AW        = $clog2(TBL_DEPTH);
  localparam logic [CNT_W-1:0] LVL_LIM = CNT_W'(TBL_DEPTH);

  // config registers
  logic [1:0]       mode_r;
  logic [UV_W-1:0]  base_r;
  logic [UV_W-1:0]  step_r;
  logic [CNT_W-1:0] lvl_cnt_r;
  logic [UV_W-1:0]  const_r;
  logic [SEL_W-1:0] taddr_r;

  // sequencer and datapath
  state_t           state_r, state_nxt;
  logic [UV_W-1:0]  lo_r, lo_nxt;
  logic [UV_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [SEL_W-1:0] idx_r, idx_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             tbl_r, tbl_nxt;     // table source, else linear
  logic             lvl_r, lvl_nxt;     // table or linear item (selector latches)
  logic [SEL_W-1:0] cur_sel_r, cur_sel_nxt;

  logic             o_status_r, o_status_nxt;
  logic [SEL_W-1:0] o_sel_r, o_sel_nxt;
  logic [UV_W-1:0]  o_uv_r, o_uv_nxt;

  logic             in_acc;
  logic             last;
  logic [CNT_W-1:0] n_use;
  logic             is_lvl_mode;
  logic [SEL_W-1:0] raddr_full;
  logic [UV_W-1:0]  rdata;
  logic             tbl_we;
  logic [ACC_W-1:0] cand;
  unit_res_t        ures;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_DONE);
  assign out_tdata  = {{(OUT_TDATA_W - 1 - SEL_W - UV_W){1'b0}}, o_uv_r, o_sel_r, o_status_r};

  assign n_use       = (lvl_cnt_r > LVL_LIM) ? LVL_LIM : lvl_cnt_r;
  assign is_lvl_mode = (mode_r == MODE_TABLE) || (mode_r == MODE_LINEAR);
  assign last        = ({1'b0, idx_r} == (n_r - CNT_W'(1)));

  // config writes; table_data itself is not kept, it goes straight to the RAM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_TABLE;
      base_r    <= '0;
      step_r    <= '0;
      lvl_cnt_r <= '0;
      const_r   <= '0;
      taddr_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode_r    <= cfg_wdata[1:0];
        REG_BASE:  base_r    <= cfg_wdata;
        REG_STEP:  step_r    <= cfg_wdata;
        REG_COUNT: lvl_cnt_r <= cfg_wdata[CNT_W-1:0];
        REG_CONST: const_r   <= cfg_wdata;
        REG_TADDR: taddr_r   <= cfg_wdata[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign tbl_we = cfg_we && (cfg_index == REG_TDATA) && (32'(taddr_r) < TBL_DEPTH);

  // level table: prefetch entry 0 while idle, then idx+1 while idx is tested
  assign raddr_full = (state_r == ST_SCAN) ? (idx_r + SEL_W'(1)) : '0;

  rvs_ram #(
    .WIDTH (UV_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (taddr_r[AW-1:0]),
    .wdata (cfg_wdata),
    .raddr (raddr_full[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    if (state_r == ST_CONST) begin
      cand = {{SEL_W{1'b0}}, const_r};
    end else if (tbl_r) begin
      cand = {{SEL_W{1'b0}}, rdata};
    end else begin
      cand = acc_r;
    end
  end

  rvs_unit u_unit (
    .cand (cand),
    .lo   (lo_r),
    .hi   (hi_r),
    .acc  (acc_r),
    .step (step_r),
    .res  (ures)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!is_lvl_mode) begin
            state_nxt = ST_CONST;
          end else if (n_use == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (ures.fit || last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_CONST: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    n_nxt        = n_r;
    idx_nxt      = idx_r;
    acc_nxt      = acc_r;
    tbl_nxt      = tbl_r;
    lvl_nxt      = lvl_r;
    cur_sel_nxt  = cur_sel_r;
    o_status_nxt = o_status_r;
    o_sel_nxt    = o_sel_r;
    o_uv_nxt     = o_uv_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          lo_nxt       = in_tdata[UV_W-1:0];
          hi_nxt       = in_tdata[2*UV_W-1:UV_W];
          n_nxt        = n_use;
          idx_nxt      = '0;
          acc_nxt      = {{SEL_W{1'b0}}, base_r};
          tbl_nxt      = (mode_r == MODE_TABLE);
          lvl_nxt      = is_lvl_mode;
          // preset failure; zero levels ends right here
          o_status_nxt = STATUS_FAIL;
          o_sel_nxt    = '0;
          o_uv_nxt     = '0;
        end
      end
      ST_SCAN: begin
        if (ures.fit) begin
          o_status_nxt = STATUS_OK;
          o_sel_nxt    = idx_r;
          o_uv_nxt     = cand[UV_W-1:0];
          cur_sel_nxt  = idx_r;
        end else if (!last) begin
          idx_nxt = idx_r + SEL_W'(1);
          acc_nxt = ures.next;
        end
      end
      ST_CONST: begin
        if (ures.fit) begin
          o_status_nxt = STATUS_OK;
          o_uv_nxt     = const_r;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cur_sel_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cur_sel_r <= cur_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    tbl_r      <= tbl_nxt;
    lvl_r      <= lvl_nxt;
    o_status_r <= o_status_nxt;
    o_sel_r    <= o_sel_nxt;
    o_uv_r     <= o_uv_nxt;
  end

  // one item in flight: never ready while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // an accepted item always starts work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("still ready right after accepting an item");

  // failure reports zero selector and voltage
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (o_status_r == STATUS_FAIL) |-> (o_sel_r == '0) && (o_uv_r == '0))
    else $error("failed result carries a selector or voltage");

  // a table or linear success has latched its selector
  a_sel_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && lvl_r && (o_status_r == STATUS_OK) |-> (cur_sel_r == o_sel_r))
    else $error("current selector does not match the reported one");

endmodule
